@@ design/uce_pkg.sv @@
// Shared types and constants for the universal code encoder.
// Used by universal_code_encoder and its port checker; depends on nothing.
package uce_pkg;

  // Code kinds carried on the input tuser
  typedef enum logic [2:0] {
    ACT_ELIAS    = 3'd0,
    ACT_UNARY    = 3'd1,
    ACT_RICE1    = 3'd2,
    ACT_VBIN     = 3'd3,
    ACT_RAW      = 3'd4,
    ACT_ELIAS_NF = 3'd5
  } action_t;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int BCNT_W   = 6;
  localparam int CODE_W   = 64;
  localparam int LEN_W    = 7;

  // Packed stream widths (tdata padded to whole bytes)
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 2;

  // Bit positions inside the result tuser
  localparam int USR_FLAG = 0;
  localparam int USR_ERR  = 1;

endpackage

@@ design/universal_code_encoder.sv @@
// Universal code encoder: three-stage pipeline producing one code word per request.
// Depends on uce_pkg (code kinds, field widths).
//
// Usage:
//   Input channel (in_*): in_tuser carries the code kind, in_tdata the value and the
//   bit count for plain binary. Result channel (out_*): out_tdata carries the code
//   word, right-aligned with the first bit to send as MSB, and its length; out_tuser
//   carries has_flag and error.
//   A request is loaded into the input stage when it is accepted, then passes the
//   code build stage and the output register before it shows on out_tvalid.
//   Throughput: one request per cycle while out_tready is high; every stage has
//   its own valid bit, so all three can hold requests at once.
//   Stall: when out_tready is low the output register holds; each earlier stage
//   still fills while it is empty, so up to three requests sit in the block
//   before in_tready drops. Nothing is lost or repeated.
//   Reset: rst_n low clears every valid bit; the block is ready in the next cycle.
//   Codes longer than MAX_CODE_BITS, a zero value for the Elias kinds, a zero bit
//   count for plain binary and unknown kinds give error with length 0.
module universal_code_encoder #(
  parameter int MAX_CODE_BITS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: value[31:0], bit_count[37:32], zeros[39:38]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [uce_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: action[2:0]
  input  logic [uce_pkg::ACTION_W-1:0]     in_tuser,
  // out_tdata: code_bits[63:0], code_length[70:64], zero[71]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [uce_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: has_flag[0], error[1]
  output logic [uce_pkg::OUT_USER_W-1:0]   out_tuser
);

  localparam logic [6:0]  MAX_L    = 7'(MAX_CODE_BITS);
  localparam logic [31:0] MAX_V    = 32'(MAX_CODE_BITS);
  localparam int          GMAX     = (MAX_CODE_BITS - 2) / 2;
  localparam logic [31:0] VB_LIMIT = 32'(3 * (GMAX + 1));

  // ---------------------------------------------------------------------------
  // Stage 1: length, error and helper counts
  // ---------------------------------------------------------------------------
  logic                          s1_valid_r;
  uce_pkg::action_t              s1_act_r;
  logic [uce_pkg::VALUE_W-1:0]   s1_value_r;
  logic [uce_pkg::BCNT_W-1:0]    s1_bcnt_r;
  logic [uce_pkg::LEN_W-1:0]     s1_len_r, s1_len_nxt;
  logic                          s1_err_r, s1_err_nxt;
  logic                          s1_flag_r, s1_flag_nxt;
  logic [5:0]                    s1_ones_r, s1_ones_nxt;
  logic [1:0]                    s1_rem_r, s1_rem_nxt;

  logic                          s2_valid_r;
  logic [uce_pkg::CODE_W-1:0]    s2_code_r, s2_code_nxt;
  logic [uce_pkg::LEN_W-1:0]     s2_len_r;
  logic                          s2_err_r;
  logic                          s2_flag_r;

  logic                          out_valid_r;
  logic [uce_pkg::CODE_W-1:0]    out_code_r;
  logic [uce_pkg::LEN_W-1:0]     out_len_r;
  logic                          out_err_r;
  logic                          out_flag_r;

  logic                          s1_ready, s2_ready, out_ready;

  uce_pkg::action_t              in_act;
  logic [uce_pkg::VALUE_W-1:0]   in_value;
  logic [uce_pkg::BCNT_W-1:0]    in_bcnt;
  logic [4:0]                    top_idx;
  logic [31:0]                   half_v;
  logic [15:0]                   div_prod;
  logic [6:0]                    grp;
  logic [7:0]                    grp3;
  logic [7:0]                    rem8;
  logic                          in_take;

  // Per-stage advance: a stage loads when it is empty or its contents move on
  assign out_ready = !out_valid_r || out_tready;
  assign s2_ready  = !s2_valid_r  || out_ready;
  assign s1_ready  = !s1_valid_r  || s2_ready;
  assign in_tready = s1_ready;
  assign in_take   = in_tvalid && s1_ready;

  assign in_act   = uce_pkg::action_t'(in_tuser);
  assign in_value = in_tdata[31:0];
  assign in_bcnt  = in_tdata[37:32];
  assign half_v   = in_value >> 1;

  // Index of the highest set bit
  always_comb begin
    top_idx = 5'd0;
    for (int i = 0; i < uce_pkg::VALUE_W; i++) begin
      if (in_value[i]) top_idx = 5'(i);
    end
  end

  // Divide by three through the reciprocal 171/512, exact for 8-bit operands;
  // only used where the value stays below the group limit (96 at the default width)
  assign div_prod = {8'd0, in_value[7:0]} * 16'd171;
  assign grp      = div_prod[15:9];
  assign grp3     = {grp, 1'b0} + {1'b0, grp};
  assign rem8     = in_value[7:0] - grp3;

  always_comb begin
    s1_len_nxt  = '0;
    s1_err_nxt  = 1'b0;
    s1_flag_nxt = 1'b0;
    s1_ones_nxt = '0;
    s1_rem_nxt  = '0;
    unique case (in_act)
      uce_pkg::ACT_ELIAS: begin
        s1_len_nxt = {1'b0, top_idx, 1'b1};
        s1_err_nxt = (in_value == 32'd0) || (s1_len_nxt > MAX_L);
      end
      uce_pkg::ACT_UNARY: begin
        s1_len_nxt  = in_value[6:0] + 7'd1;
        s1_ones_nxt = in_value[5:0];
        s1_err_nxt  = (in_value >= MAX_V);
      end
      uce_pkg::ACT_RICE1: begin
        s1_len_nxt  = half_v[6:0] + 7'd2;
        s1_ones_nxt = half_v[5:0];
        s1_err_nxt  = (half_v > (MAX_V - 32'd2));
      end
      uce_pkg::ACT_VBIN: begin
        s1_len_nxt  = {grp[5:0], 1'b0} + 7'd2;
        s1_ones_nxt = {grp[4:0], 1'b0};
        s1_rem_nxt  = rem8[1:0];
        s1_err_nxt  = (in_value >= VB_LIMIT);
      end
      uce_pkg::ACT_RAW: begin
        s1_len_nxt = {1'b0, in_bcnt};
        s1_err_nxt = (in_bcnt == '0) || (s1_len_nxt > MAX_L);
      end
      uce_pkg::ACT_ELIAS_NF: begin
        // value one sends nothing and is no error
        s1_len_nxt  = {1'b0, top_idx, 1'b0};
        s1_err_nxt  = (in_value == 32'd0) || (s1_len_nxt > MAX_L);
        s1_flag_nxt = (in_value > 32'd1) && !s1_err_nxt;
      end
      default: begin
        s1_err_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_act_r   <= in_act;
      s1_value_r <= in_value;
      s1_bcnt_r  <= in_bcnt;
      s1_len_r   <= s1_len_nxt;
      s1_err_r   <= s1_err_nxt;
      s1_flag_r  <= s1_flag_nxt;
      s1_ones_r  <= s1_ones_nxt;
      s1_rem_r   <= s1_rem_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: build the code word
  // ---------------------------------------------------------------------------
  logic [30:0]                 above;
  logic [uce_pkg::CODE_W-1:0]  run_mask;
  logic [uce_pkg::CODE_W-1:0]  raw_mask;

  // above[i]: bit i lies below the top set bit, so it is sent
  always_comb begin
    for (int i = 0; i < 31; i++) begin
      above[i] = |(s1_value_r >> (i + 1));
    end
  end

  assign run_mask = ~({uce_pkg::CODE_W{1'b1}} << s1_ones_r);
  assign raw_mask = ~({uce_pkg::CODE_W{1'b1}} << s1_bcnt_r);

  always_comb begin
    s2_code_nxt = '0;
    unique case (s1_act_r)
      uce_pkg::ACT_ELIAS: begin
        // pairs of flag one and data bit, closed by a single zero
        for (int i = 0; i < 31; i++) begin
          s2_code_nxt[2*i+2] = above[i];
          s2_code_nxt[2*i+1] = above[i] & s1_value_r[i];
        end
      end
      uce_pkg::ACT_UNARY: begin
        s2_code_nxt = run_mask << 1;
      end
      uce_pkg::ACT_RICE1: begin
        s2_code_nxt = (run_mask << 2) | {63'd0, s1_value_r[0]};
      end
      uce_pkg::ACT_VBIN: begin
        s2_code_nxt = (run_mask << 2) | {62'd0, s1_rem_r};
      end
      uce_pkg::ACT_RAW: begin
        s2_code_nxt = {32'd0, s1_value_r} & raw_mask;
      end
      uce_pkg::ACT_ELIAS_NF: begin
        // data bit then a continue flag, the last pair ends in zero
        for (int i = 0; i < 31; i++) begin
          s2_code_nxt[2*i+1] = above[i] & s1_value_r[i];
          s2_code_nxt[2*i]   = above[i] & (i > 0);
        end
      end
      default: begin
        s2_code_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_code_r <= s2_code_nxt;
      s2_len_r  <= s1_len_r;
      s2_err_r  <= s1_err_r;
      s2_flag_r <= s1_flag_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: output register, errors force an empty word
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_valid_r) begin
      out_code_r <= s2_err_r ? '0 : s2_code_r;
      out_len_r  <= s2_err_r ? '0 : s2_len_r;
      out_flag_r <= s2_flag_r && !s2_err_r;
      out_err_r  <= s2_err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_len_r, out_code_r};
  assign out_tuser  = {out_err_r, out_flag_r};

endmodule

@@ design/uce_checker.sv @@
// Port-level checker for universal_code_encoder, bound to the encoder by the bind below.
// Depends on uce_pkg for field widths and tuser bit positions.
module uce_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [uce_pkg::IN_DATA_W-1:0]    in_tdata,
  input logic [uce_pkg::ACTION_W-1:0]     in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [uce_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic [uce_pkg::OUT_USER_W-1:0]   out_tuser
);

  logic [uce_pkg::CODE_W-1:0] code;
  logic [uce_pkg::LEN_W-1:0]  len;
  logic                       flag;
  logic                       err;

  assign code = out_tdata[63:0];
  assign len  = out_tdata[70:64];
  assign flag = out_tuser[uce_pkg::USR_FLAG];
  assign err  = out_tuser[uce_pkg::USR_ERR];

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Errors carry an empty word and no flag
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && err |-> code == '0 && len == '0 && !flag)
    else $error("error result not empty");

  // Flagged Elias words are non-empty with an even length
  a_flag_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && flag |-> !err && len != '0 && !len[0])
    else $error("flagged result has bad length");

  // No code bits above the stated length
  a_right_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (code >> len) == '0 && len <= 7'd64)
    else $error("code bits beyond length");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind universal_code_encoder uce_checker u_uce_checker (.*);

@@ sim/universal_code_encoder_tb.sv @@
// Self-checking bench for universal_code_encoder: directed and random requests of every code
// kind, with random idling on both stream sides. Depends on uce_pkg and the encoder RTL.
`timescale 1ns / 100ps

module universal_code_encoder_tb;

  localparam int CODE_LIMIT = 64;
  localparam int N_RANDOM   = 1650;
  localparam int IDLE_PCT   = 23;
  localparam int MAX_CYCLES = 200000;
  localparam int DRAIN_WAIT = 12;

  // Kinds the block must reject
  localparam logic [uce_pkg::ACTION_W-1:0] ACT_UNDEF_LO = 3'd6;
  localparam logic [uce_pkg::ACTION_W-1:0] ACT_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic [uce_pkg::ACTION_W-1:0] kind;
    logic [uce_pkg::VALUE_W-1:0]  value;
    logic [uce_pkg::BCNT_W-1:0]   nbits;
  } code_req_t;

  typedef struct packed {
    logic [uce_pkg::CODE_W-1:0] bits;
    logic [uce_pkg::LEN_W-1:0]  len;
    logic                       flag;
    logic                       err;
  } code_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [uce_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [uce_pkg::ACTION_W-1:0]   in_tuser   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [uce_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [uce_pkg::OUT_USER_W-1:0] out_tuser;

  code_req_t  code_reqs[$];
  code_word_t expected_codes[$];
  logic       in_fire     = 1'b0;
  int         reqs_taken  = 0;
  int         mismatches  = 0;
  int         cycle_count = 0;
  logic       calm;

  universal_code_encoder #(
    .MAX_CODE_BITS(CODE_LIMIT)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mask of the low n bits
  function automatic logic [uce_pkg::CODE_W-1:0] low_ones(int n);
    if (n >= uce_pkg::CODE_W) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // Expected code word for one request
  function automatic code_word_t encode_word(code_req_t req);
    code_word_t w;
    logic [63:0] len;
    logic [31:0] groups;
    int msb;
    w = '0;
    len = '0;
    msb = 0;
    groups = req.value / 3;
    for (int i = 0; i < uce_pkg::VALUE_W; i++) if (req.value[i]) msb = i;
    case (req.kind)
      uce_pkg::ACT_ELIAS: begin
        if (req.value == 0) begin
          w.err = 1'b1;
        end else begin
          // a 1 marker before each bit below the top one, closing 0
          for (int i = msb; i > 0; i--)
            w.bits = (w.bits << 2) | 64'd2 | 64'(req.value[i-1]);
          w.bits = w.bits << 1;
          len = 64'(2 * msb + 1);
        end
      end
      uce_pkg::ACT_UNARY: begin
        len = 64'(req.value) + 64'd1;
        if (len <= CODE_LIMIT) w.bits = low_ones(int'(req.value)) << 1;
      end
      uce_pkg::ACT_RICE1: begin
        len = 64'(req.value >> 1) + 64'd2;
        if (len <= CODE_LIMIT)
          w.bits = (low_ones(int'(req.value >> 1)) << 2) | 64'(req.value[0]);
      end
      uce_pkg::ACT_VBIN: begin
        len = 2 * 64'(groups) + 64'd2;
        if (len <= CODE_LIMIT)
          w.bits = (low_ones(2 * int'(groups))) << 2 | 64'(req.value - 3 * groups);
      end
      uce_pkg::ACT_RAW: begin
        if (req.nbits == 0) begin
          w.err = 1'b1;
        end else begin
          len = 64'(req.nbits);
          w.bits = 64'(req.value) & low_ones(int'(req.nbits));
        end
      end
      uce_pkg::ACT_ELIAS_NF: begin
        if (req.value == 0) begin
          w.err = 1'b1;
        end else if (req.value != 1) begin
          // each bit followed by a continue marker, 0 after the last
          for (int i = msb; i > 0; i--)
            w.bits = (w.bits << 2) | (64'(req.value[i-1]) << 1) | ((i > 1) ? 64'd1 : 64'd0);
          len = 64'(2 * msb);
          w.flag = 1'b1;
        end
      end
      default: w.err = 1'b1;
    endcase
    if (!w.err && len > CODE_LIMIT) w.err = 1'b1;
    if (w.err) begin
      w.bits = '0;
      w.flag = 1'b0;
      len = '0;
    end
    w.len = len[uce_pkg::LEN_W-1:0];
    return w;
  endfunction

  task automatic add_req(logic [uce_pkg::ACTION_W-1:0] kind,
                         logic [uce_pkg::VALUE_W-1:0] value,
                         logic [uce_pkg::BCNT_W-1:0] nbits);
    code_req_t r;
    r.kind = kind;
    r.value = value;
    r.nbits = nbits;
    code_reqs.push_back(r);
  endtask

  // Stretch with no idling on either side
  assign calm = (reqs_taken >= 700) && (reqs_taken < 1000);

  // Request driver
  always @(negedge clk) begin
    code_req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (code_reqs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        r = code_reqs.pop_front();
        in_tdata  <= {2'b00, r.nbits, r.value};
        in_tuser  <= r.kind;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result back-pressure
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    code_word_t want;
    code_req_t  got_req;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_codes.size() == 0) begin
          $display("%0t: result with nothing expected: bits %h len %0d flag %b err %b",
                   $time, out_tdata[63:0], out_tdata[70:64], out_tuser[uce_pkg::USR_FLAG],
                   out_tuser[uce_pkg::USR_ERR]);
          mismatches++;
        end else begin
          want = expected_codes.pop_front();
          if (out_tdata[63:0] !== want.bits) begin
            $display("%0t: code_bits expected %h actual %h", $time, want.bits,
                     out_tdata[63:0]);
            mismatches++;
          end
          if (out_tdata[70:64] !== want.len) begin
            $display("%0t: code_length expected %0d actual %0d", $time, want.len,
                     out_tdata[70:64]);
            mismatches++;
          end
          if (out_tuser[uce_pkg::USR_FLAG] !== want.flag) begin
            $display("%0t: has_flag expected %b actual %b", $time, want.flag,
                     out_tuser[uce_pkg::USR_FLAG]);
            mismatches++;
          end
          if (out_tuser[uce_pkg::USR_ERR] !== want.err) begin
            $display("%0t: error expected %b actual %b", $time, want.err,
                     out_tuser[uce_pkg::USR_ERR]);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        got_req.kind  = in_tuser;
        got_req.value = in_tdata[31:0];
        got_req.nbits = in_tdata[37:32];
        expected_codes.push_back(encode_word(got_req));
        reqs_taken++;
      end
      in_fire <= in_tvalid && in_tready;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("FAIL universal_code_encoder");
      $finish;
    end
  end

  initial begin
    logic [uce_pkg::ACTION_W-1:0] kind;
    logic [uce_pkg::VALUE_W-1:0]  value;
    logic [uce_pkg::BCNT_W-1:0]   nbits;

    // Directed: field extremes, length limits and the rejected cases
    add_req(uce_pkg::ACT_ELIAS, 32'd0, 6'd0);
    add_req(uce_pkg::ACT_ELIAS, 32'd1, 6'd0);
    add_req(uce_pkg::ACT_ELIAS, 32'd2, 6'd63);
    add_req(uce_pkg::ACT_ELIAS, 32'hFFFF_FFFF, 6'd0);
    add_req(uce_pkg::ACT_UNARY, 32'd0, 6'd0);
    add_req(uce_pkg::ACT_UNARY, 32'd63, 6'd0);
    add_req(uce_pkg::ACT_UNARY, 32'd64, 6'd0);
    add_req(uce_pkg::ACT_UNARY, 32'hFFFF_FFFF, 6'd0);
    add_req(uce_pkg::ACT_RICE1, 32'd1, 6'd0);
    add_req(uce_pkg::ACT_RICE1, 32'd125, 6'd0);
    add_req(uce_pkg::ACT_RICE1, 32'd126, 6'd0);
    add_req(uce_pkg::ACT_VBIN, 32'd2, 6'd0);
    add_req(uce_pkg::ACT_VBIN, 32'd95, 6'd0);
    add_req(uce_pkg::ACT_VBIN, 32'd96, 6'd0);
    add_req(uce_pkg::ACT_VBIN, 32'hFFFF_FFFF, 6'd0);
    add_req(uce_pkg::ACT_RAW, 32'hFFFF_FFFF, 6'd0);
    add_req(uce_pkg::ACT_RAW, 32'hFFFF_FFFF, 6'd1);
    add_req(uce_pkg::ACT_RAW, 32'hA5A5_5A5A, 6'd32);
    add_req(uce_pkg::ACT_RAW, 32'hFFFF_FFFF, 6'd63);
    add_req(uce_pkg::ACT_ELIAS_NF, 32'd0, 6'd0);
    add_req(uce_pkg::ACT_ELIAS_NF, 32'd1, 6'd0);
    add_req(uce_pkg::ACT_ELIAS_NF, 32'd2, 6'd0);
    add_req(uce_pkg::ACT_ELIAS_NF, 32'hFFFF_FFFF, 6'd0);
    add_req(ACT_UNDEF_LO, 32'd5, 6'd5);
    add_req(ACT_UNDEF_HI, 32'hFFFF_FFFF, 6'd63);

    // Random: varied magnitudes, small values where long codes would overflow
    for (int k = 0; k < N_RANDOM; k++) begin
      if ($urandom_range(99) < 4)
        kind = $urandom_range(1) ? ACT_UNDEF_HI : ACT_UNDEF_LO;
      else
        kind = 3'($urandom_range(uce_pkg::ACT_ELIAS_NF, uce_pkg::ACT_ELIAS));
      value = $urandom >> $urandom_range(31, 0);
      case (kind)
        uce_pkg::ACT_UNARY: if ($urandom_range(3) != 0) value = $urandom_range(70, 0);
        uce_pkg::ACT_RICE1: if ($urandom_range(3) != 0) value = $urandom_range(140, 0);
        uce_pkg::ACT_VBIN:  if ($urandom_range(3) != 0) value = $urandom_range(100, 0);
        default: ;
      endcase
      if ($urandom_range(19) == 0) value = $urandom_range(1, 0);
      if ($urandom_range(9) == 0) nbits = $urandom_range(63, 0);
      else nbits = $urandom_range(32, 1);
      if ($urandom_range(49) == 0) nbits = '0;
      add_req(kind, value, nbits);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Drain: every request taken, then every result back
    while (code_reqs.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_codes.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS universal_code_encoder");
    end else begin
      $display("FAIL universal_code_encoder");
    end
    $finish;
  end

endmodule
